/* src/csv_split_pkg.sv */
// Shared types and constants for the CSV record field splitter.
`timescale 1ns / 1ps
`default_nettype none

package csv_split_pkg;

    // Largest column count that a record may use; larger settings are clamped.
    localparam int MAX_COLUMNS = 64;

    // Default width of the held-back blank counter.
    localparam int BLANK_COUNT_BITS = 16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        MODE_START       = 3'd0,
        MODE_PLAIN       = 3'd1,
        MODE_QUOTED      = 3'd2,
        MODE_AFTER_QUOTE = 3'd3,
        MODE_TRAIL       = 3'd4,
        MODE_DISCARD     = 3'd5
    } parse_mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2
    } rec_status_t;

endpackage

`default_nettype wire

/* src/csv_record_field_splitter_unit.sv */
// CSV record field splitter: tokenizes one record byte per word into columns.
// Each accepted byte word passes through the input register and then the result register.
// One byte word per cycle while the result stream is not stalled; the parse update is combinational between registers.
// Reset (aresetn low, synchronous): pipeline empty, parser at field start of column zero,
// no held blanks, no error, column_count back to one.
`timescale 1ns / 1ps
`default_nettype none

module csv_record_field_splitter_unit #(
    parameter int BLANK_COUNT_BITS = csv_split_pkg::BLANK_COUNT_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write channel: column_count.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,

    // Byte input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] char_out, [23:8] blanks_before, [29:24] column_index, [31:30] status
    output logic [31:0]      m_tdata,
    // [0] char_valid, [1] field_end
    output logic [1:0]       m_tuser,
    output logic             m_tlast    // record_end
);

    // The blank counter is compared against the 16-bit output range in a
    // width large enough for both.
    localparam int SAT_W = (BLANK_COUNT_BITS > 16) ? BLANK_COUNT_BITS : 16;

    // ------------------------------------------------------------------
    // Configuration. The user must write only while the block is idle;
    // the block does not enforce this, and the register is always ready.
    // ------------------------------------------------------------------
    logic [6:0] column_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= 7'd1;
        end else if (cfg_valid) begin
            column_count_reg <= cfg_data;
        end
    end

    // Effective column count: zero acts as one, values above the maximum
    // are clamped to it.
    logic [6:0] eff_count;

    always_comb begin
        if (column_count_reg == 7'd0) begin
            eff_count = 7'd1;
        end else if ({2'b00, column_count_reg} > 9'(csv_split_pkg::MAX_COLUMNS)) begin
            eff_count = 7'(csv_split_pkg::MAX_COLUMNS);
        end else begin
            eff_count = column_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. The input register takes a new byte whenever it
    // is empty or its byte moves on into the result register in this cycle,
    // so one byte can wait in front of a stalled result.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Parser state.
    // ------------------------------------------------------------------
    csv_split_pkg::parse_mode_t   mode_reg, mode_next;
    logic [6:0]                   counter_reg, counter_next;
    logic [BLANK_COUNT_BITS-1:0]  pending_reg, pending_next;
    csv_split_pkg::rec_status_t   error_reg, error_next;

    logic is_zero, is_quote, is_comma, is_space;
    logic [6:0] counter_inc;
    logic cnt_full, inc_full;

    assign is_zero     = (in_byte_reg == csv_split_pkg::CHAR_NUL);
    assign is_quote    = (in_byte_reg == csv_split_pkg::CHAR_QUOTE);
    assign is_comma    = (in_byte_reg == csv_split_pkg::CHAR_COMMA);
    assign is_space    = (in_byte_reg == csv_split_pkg::CHAR_SPACE);
    assign counter_inc = counter_reg + 7'd1;
    assign cnt_full    = (counter_reg >= eff_count);
    assign inc_full    = (counter_inc >= eff_count);

    // Actions the current byte triggers: take it as a field character (a
    // space only adds to the held count), close the open field, finish
    // the record with a status.
    logic                       do_take;
    logic                       do_close;
    logic                       do_finish;
    csv_split_pkg::rec_status_t finish_status;
    csv_split_pkg::parse_mode_t mode_after;
    csv_split_pkg::rec_status_t error_after;
    logic                       start_path;
    logic                       extra_path;

    // Next-state decode.
    always_comb begin
        do_take       = 1'b0;
        do_close      = 1'b0;
        do_finish     = 1'b0;
        finish_status = csv_split_pkg::ST_OK;
        mode_after    = mode_reg;
        error_after   = error_reg;
        start_path    = 1'b0;
        extra_path    = 1'b0;

        unique case (mode_reg)
            csv_split_pkg::MODE_PLAIN: begin
                if (is_zero || is_comma) begin
                    do_close = 1'b1;
                    if (is_zero) begin
                        do_finish     = 1'b1;
                        finish_status = inc_full ? csv_split_pkg::ST_OK
                                                 : csv_split_pkg::ST_FEW;
                    end else begin
                        mode_after = inc_full ? csv_split_pkg::MODE_TRAIL
                                              : csv_split_pkg::MODE_START;
                    end
                end else begin
                    do_take = 1'b1;
                end
            end
            csv_split_pkg::MODE_QUOTED: begin
                if (is_zero) begin
                    // An unterminated quote is closed by the record end.
                    do_close      = 1'b1;
                    do_finish     = 1'b1;
                    finish_status = inc_full ? csv_split_pkg::ST_OK
                                             : csv_split_pkg::ST_FEW;
                end else if (is_quote) begin
                    do_close   = 1'b1;
                    mode_after = csv_split_pkg::MODE_AFTER_QUOTE;
                end else begin
                    do_take = 1'b1;
                end
            end
            csv_split_pkg::MODE_AFTER_QUOTE: begin
                // The separating comma after a closing quote is swallowed;
                // while columns remain, any other byte already belongs to the next column.
                if (!cnt_full) begin
                    if (is_comma) begin
                        mode_after = csv_split_pkg::MODE_START;
                    end else begin
                        start_path = 1'b1;
                    end
                end else if (is_comma) begin
                    mode_after = csv_split_pkg::MODE_TRAIL;
                end else begin
                    extra_path = 1'b1;
                end
            end
            csv_split_pkg::MODE_TRAIL: begin
                extra_path = 1'b1;
            end
            csv_split_pkg::MODE_DISCARD: begin
                if (is_zero) begin
                    do_finish     = 1'b1;
                    finish_status = error_reg;
                end
            end
            default: begin
                start_path = 1'b1;
            end
        endcase

        if (start_path) begin
            if (is_zero) begin
                do_finish     = 1'b1;
                finish_status = csv_split_pkg::ST_FEW;
            end else if (is_quote) begin
                mode_after = csv_split_pkg::MODE_QUOTED;
            end else if (is_comma) begin
                do_close   = 1'b1;
                mode_after = inc_full ? csv_split_pkg::MODE_TRAIL
                                      : csv_split_pkg::MODE_START;
            end else begin
                do_take    = 1'b1;
                mode_after = csv_split_pkg::MODE_PLAIN;
            end
        end

        if (extra_path) begin
            // Past the last column: only the record end is still fine.
            if (is_zero) begin
                do_finish     = 1'b1;
                finish_status = csv_split_pkg::ST_OK;
            end else begin
                error_after = csv_split_pkg::ST_MANY;
                mode_after  = csv_split_pkg::MODE_DISCARD;
            end
        end
    end

    // Register next values; a finished record returns everything to the
    // field start of column zero.
    always_comb begin
        mode_next    = mode_reg;
        counter_next = counter_reg;
        pending_next = pending_reg;
        error_next   = error_reg;
        if (step) begin
            if (do_finish) begin
                mode_next    = csv_split_pkg::MODE_START;
                counter_next = 7'd0;
                pending_next = '0;
                error_next   = csv_split_pkg::ST_OK;
            end else begin
                mode_next  = mode_after;
                error_next = error_after;
                if (do_close) begin
                    counter_next = counter_inc;
                    pending_next = '0;
                end else if (do_take) begin
                    if (!is_space) begin
                        pending_next = '0;
                    end else if (pending_reg != {BLANK_COUNT_BITS{1'b1}}) begin
                        pending_next = pending_reg + BLANK_COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= csv_split_pkg::MODE_START;
            counter_reg <= 7'd0;
            pending_reg <= '0;
            error_reg   <= csv_split_pkg::ST_OK;
        end else begin
            mode_reg    <= mode_next;
            counter_reg <= counter_next;
            pending_reg <= pending_next;
            error_reg   <= error_next;
        end
    end

    // ------------------------------------------------------------------
    // Result fields.
    // ------------------------------------------------------------------
    logic             emit_char;
    logic [SAT_W-1:0] pending_ext;
    logic [15:0]      blanks_sat;
    logic             char_valid_c;
    logic [7:0]       char_out_c;
    logic [15:0]      blanks_before_c;
    logic             field_end_c;
    logic [5:0]       column_index_c;
    logic             record_end_c;
    logic [1:0]       status_c;

    assign pending_ext = SAT_W'(pending_reg);
    assign blanks_sat  = (pending_ext > SAT_W'(16'hFFFF)) ? 16'hFFFF : pending_ext[15:0];
    assign emit_char   = do_take && !is_space;

    always_comb begin
        char_valid_c    = emit_char;
        char_out_c      = emit_char ? in_byte_reg : 8'd0;
        blanks_before_c = emit_char ? blanks_sat : 16'd0;
        field_end_c     = do_close;
        column_index_c  = (emit_char || do_close) ? counter_reg[5:0] : 6'd0;
        record_end_c    = do_finish;
        status_c        = do_finish ? finish_status : csv_split_pkg::ST_OK;
    end

    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= {status_c, column_index_c, blanks_before_c, char_out_c};
            m_tuser_reg <= {field_end_c, char_valid_c};
            m_tlast_reg <= record_end_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire
